>>> hdl/psl_pkg.sv
// Shared types and constants for the passive serial configuration loader.
`timescale 1ns / 1ps
`default_nettype none

package psl_pkg;

    localparam int LEN_W = 25;
    localparam logic [LEN_W-1:0] LEN_RESET = 25'd1191789;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_DONE        = 3'd1;
    localparam logic [2:0] ST_START_HIGH  = 3'd2;
    localparam logic [2:0] ST_NSTATUS_LOW = 3'd3;
    localparam logic [2:0] ST_CDONE_LOW   = 3'd4;
    localparam logic [2:0] ST_SEQ_ERR     = 3'd5;

    localparam logic [3:0] STEP_START_LAST  = 4'd1;
    localparam logic [3:0] STEP_BYTE_LAST   = 4'd15;
    localparam logic [3:0] STEP_FINISH_LAST = 4'd4;

    typedef enum logic [1:0] {
        CMD_SINGLE,
        CMD_START,
        CMD_BYTE,
        CMD_FINISH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  byte_val;
        logic        pin;
        logic        ncfg;
        logic [2:0]  status;
    } cmd_t;

endpackage

`default_nettype wire

>>> hdl/fpga_passive_serial_loader.sv
// Top level of the passive serial configuration loader.
// Accepted commands pass through the queue and then the sequencer output register.
// One result per cycle leaves the output register while a command waits and out_stall is low;
// a data byte gives sixteen results, a successful start two, a successful finish five, else one.
// The command queue lets the next transaction be accepted while results are still being sent.
// Reset clears the load state and the queue and sets the bitstream length to 1191789 bytes.
`timescale 1ns / 1ps
`default_nettype none

module fpga_passive_serial_loader
    import psl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [LEN_W-1:0] cfg_wr_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [1:0]       opcode,
    input  wire logic [7:0]       data_byte,
    input  wire logic             nstatus_level,
    input  wire logic             conf_done_level,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic                  nconfig_level,
    output logic                  dclk_level,
    output logic                  data_level,
    output logic [2:0]            status,
    output logic                  last
);

    logic q_full, push, pop, head_valid;
    cmd_t push_cmd, head_cmd;

    psl_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .data_byte       (data_byte),
        .nstatus_level   (nstatus_level),
        .conf_done_level (conf_done_level),
        .q_full          (q_full),
        .push            (push),
        .cmd             (push_cmd)
    );

    psl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    psl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .nconfig_level (nconfig_level),
        .dclk_level    (dclk_level),
        .data_level    (data_level),
        .status        (status),
        .last          (last)
    );

endmodule

`default_nettype wire

>>> hdl/psl_front.sv
// Front end: accepts transactions, tracks the load sequence and issues pin commands.
`timescale 1ns / 1ps
`default_nettype none

module psl_front
    import psl_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [LEN_W-1:0] cfg_wr_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [1:0]       opcode,
    input  wire logic [7:0]       data_byte,
    input  wire logic             nstatus_level,
    input  wire logic             conf_done_level,
    input  wire logic             q_full,
    output logic                  push,
    output cmd_t                  cmd
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LOADING,
        PH_DONE,
        PH_FAILED,
        PH_START_FAILED
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  bytes_reg, bytes_next;
    logic              pin_reg, pin_next;
    logic [LEN_W-1:0]  len_reg;
    logic              loading;

    assign in_stall = q_full;
    assign push     = in_valid && !in_stall;
    assign loading  = (phase_reg == PH_LOADING);

    always_comb
    begin
        phase_next   = phase_reg;
        bytes_next   = bytes_reg;
        pin_next     = pin_reg;
        cmd.kind     = CMD_SINGLE;
        cmd.byte_val = data_byte;
        cmd.pin      = pin_reg;
        cmd.ncfg     = (phase_reg == PH_START_FAILED) ? 1'b0 : 1'b1;
        cmd.status   = ST_SEQ_ERR;
        priority if (opcode == OP_START)
        begin
            if (nstatus_level)
            begin
                cmd.ncfg   = 1'b0;
                cmd.status = ST_START_HIGH;
                phase_next = PH_START_FAILED;
            end
            else
            begin
                cmd.kind   = CMD_START;
                cmd.status = ST_OK;
                phase_next = PH_LOADING;
                bytes_next = '0;
            end
        end
        else if (opcode == OP_DATA && loading && bytes_reg < len_reg)
        begin
            cmd.kind = CMD_BYTE;
            pin_next = data_byte[7];
            if (nstatus_level)
            begin
                cmd.status = ST_OK;
                bytes_next = bytes_reg + 1'b1;
            end
            else
            begin
                cmd.status = ST_NSTATUS_LOW;
                phase_next = PH_FAILED;
            end
        end
        else if (opcode == OP_FINISH && loading && bytes_reg >= len_reg)
        begin
            if (conf_done_level)
            begin
                cmd.kind   = CMD_FINISH;
                cmd.status = ST_DONE;
                pin_next   = 1'b0;
                phase_next = PH_DONE;
            end
            else
            begin
                cmd.ncfg   = 1'b1;
                cmd.status = ST_CDONE_LOW;
                phase_next = PH_FAILED;
            end
        end
        else
        begin
            cmd.kind = CMD_SINGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bytes_reg <= '0;
            pin_reg   <= 1'b0;
            len_reg   <= LEN_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                len_reg <= cfg_wr_data;
            end
            if (push)
            begin
                phase_reg <= phase_next;
                bytes_reg <= bytes_next;
                pin_reg   <= pin_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/psl_queue.sv
// Small command queue between the front end and the pin sequencer.
`timescale 1ns / 1ps
`default_nettype none

module psl_queue
    import psl_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/psl_back.sv
// Pin sequencer: expands each command into registered pin-level results.
`timescale 1ns / 1ps
`default_nettype none

module psl_back
    import psl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic head_valid,
    input  wire cmd_t head_cmd,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_stall,
    output logic      nconfig_level,
    output logic      dclk_level,
    output logic      data_level,
    output logic [2:0] status,
    output logic      last
);

    logic [3:0] step_reg;
    logic       out_valid_reg;
    logic       ncfg_reg, dclk_reg, data_reg, last_reg;
    logic [2:0] status_reg;
    logic       can_load, load, step_last;
    logic       ncfg_next, dclk_next, data_next, last_next;
    logic [2:0] status_next;

    assign can_load = !out_valid_reg || !out_stall;
    assign load     = can_load && head_valid;
    assign pop      = load && step_last;

    always_comb
    begin
        ncfg_next   = 1'b1;
        dclk_next   = 1'b0;
        data_next   = head_cmd.pin;
        status_next = ST_OK;
        step_last   = 1'b1;
        unique case (head_cmd.kind)
            CMD_SINGLE:
            begin
                ncfg_next   = head_cmd.ncfg;
                status_next = head_cmd.status;
            end
            CMD_START:
            begin
                step_last = (step_reg == STEP_START_LAST);
                ncfg_next = step_last;
            end
            CMD_BYTE:
            begin
                step_last   = (step_reg == STEP_BYTE_LAST);
                dclk_next   = !step_reg[0];
                data_next   = head_cmd.byte_val[step_reg[3:1]];
                status_next = step_last ? head_cmd.status : ST_OK;
            end
            CMD_FINISH:
            begin
                step_last   = (step_reg == STEP_FINISH_LAST);
                dclk_next   = !step_last && !step_reg[0];
                data_next   = step_last ? 1'b0 : head_cmd.pin;
                status_next = step_last ? head_cmd.status : ST_OK;
            end
            default:
            begin
                step_last = 1'b1;
            end
        endcase
        last_next = step_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (can_load)
            begin
                out_valid_reg <= head_valid;
            end
            if (load)
            begin
                step_reg <= step_last ? '0 : step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ncfg_reg   <= ncfg_next;
            dclk_reg   <= dclk_next;
            data_reg   <= data_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign nconfig_level = ncfg_reg;
    assign dclk_level    = dclk_reg;
    assign data_level    = data_reg;
    assign status        = status_reg;
    assign last          = last_reg;

    a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |-> last_reg)
        else $error("Nonzero status on a result that is not the last of its transaction.");

    a_dclk_needs_nconfig: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && dclk_reg |-> ncfg_reg)
        else $error("DCLK driven high while nCONFIG is low.");

    a_step_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != '0 |-> head_valid)
        else $error("Sequencer is mid-command without a queued command.");

endmodule

`default_nettype wire

>>> bench/tb.sv
// Testbench for the passive serial configuration loader: directed and random load sequences.
`timescale 1ns / 1ps

module tb;
    import psl_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 420;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LOADING,
        PH_DONE,
        PH_FAILED,
        PH_START_FAILED
    } load_phase_t;

    typedef struct packed {
        logic       ncfg;
        logic       dclk;
        logic       dat;
        logic [2:0] st;
        logic       lst;
    } pin_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en;
    logic [LEN_W-1:0] cfg_wr_data;
    logic             in_valid;
    logic             in_stall;
    logic [1:0]       opcode;
    logic [7:0]       data_byte;
    logic             nstatus_level;
    logic             conf_done_level;
    logic             out_valid;
    logic             out_stall;
    logic             nconfig_level;
    logic             dclk_level;
    logic             data_level;
    logic [2:0]       status;
    logic             last;

    pin_result_t      pins_due[$];
    load_phase_t      load_phase;
    logic [LEN_W-1:0] shifted_bytes;
    logic [LEN_W-1:0] stream_len;
    logic             data_pin;
    int               mismatches = 0;
    int               items_sent = 0;
    bit               gaps_on = 1'b0;
    int               hold_len = 0;
    int               hold_seq = 0;

    fpga_passive_serial_loader dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .data_byte       (data_byte),
        .nstatus_level   (nstatus_level),
        .conf_done_level (conf_done_level),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .nconfig_level   (nconfig_level),
        .dclk_level      (dclk_level),
        .data_level      (data_level),
        .status          (status),
        .last            (last)
    );

    always #1 clk = ~clk;

    function automatic void queue_pin(input logic ncfg, input logic dclk, input logic dat,
                                      input logic [2:0] st, input logic lst);
        pins_due.push_back('{ncfg: ncfg, dclk: dclk, dat: dat, st: st, lst: lst});
    endfunction

    task automatic predict_pins(input logic [1:0] op, input logic [7:0] byte_v,
                                input logic ns, input logic cd);
        if (op == OP_START) begin
            if (ns) begin
                queue_pin(1'b0, 1'b0, data_pin, ST_START_HIGH, 1'b1);
                load_phase = PH_START_FAILED;
            end
            else begin
                queue_pin(1'b0, 1'b0, data_pin, ST_OK, 1'b0);
                queue_pin(1'b1, 1'b0, data_pin, ST_OK, 1'b1);
                load_phase = PH_LOADING;
                shifted_bytes = '0;
            end
        end
        else if (op == OP_DATA && load_phase == PH_LOADING && shifted_bytes < stream_len) begin
            for (int i = 0; i < 8; i++) begin
                data_pin = byte_v[i];
                queue_pin(1'b1, 1'b1, data_pin, ST_OK, 1'b0);
                if (i < 7)
                    queue_pin(1'b1, 1'b0, data_pin, ST_OK, 1'b0);
            end
            if (!ns) begin
                queue_pin(1'b1, 1'b0, data_pin, ST_NSTATUS_LOW, 1'b1);
                load_phase = PH_FAILED;
            end
            else begin
                queue_pin(1'b1, 1'b0, data_pin, ST_OK, 1'b1);
                shifted_bytes = shifted_bytes + 1'b1;
            end
        end
        else if (op == OP_FINISH && load_phase == PH_LOADING && shifted_bytes >= stream_len) begin
            if (!cd) begin
                queue_pin(1'b1, 1'b0, data_pin, ST_CDONE_LOW, 1'b1);
                load_phase = PH_FAILED;
            end
            else begin
                for (int i = 0; i < 2; i++) begin
                    queue_pin(1'b1, 1'b1, data_pin, ST_OK, 1'b0);
                    queue_pin(1'b1, 1'b0, data_pin, ST_OK, 1'b0);
                end
                data_pin = 1'b0;
                queue_pin(1'b1, 1'b0, 1'b0, ST_DONE, 1'b1);
                load_phase = PH_DONE;
            end
        end
        else begin
            queue_pin(load_phase != PH_START_FAILED, 1'b0, data_pin, ST_SEQ_ERR, 1'b1);
        end
    endtask

    task automatic send_item(input logic [1:0] op, input logic [7:0] byte_v,
                             input logic ns, input logic cd);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 37) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        opcode          <= op;
        data_byte       <= byte_v;
        nstatus_level   <= ns;
        conf_done_level <= cd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_pins(op, byte_v, ns, cd);
        items_sent++;
    endtask

    task automatic flush_pins();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pins_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        stream_len = len;
    endtask

    task automatic test_out_of_sequence();
        send_item(OP_DATA, 8'h3C, 1'b1, 1'b1);
        send_item(OP_FINISH, 8'h00, 1'b1, 1'b1);
        send_item(OP_NONE, 8'hFF, 1'b0, 1'b0);
        send_item(OP_START, 8'h00, 1'b1, 1'b0);
        send_item(OP_NONE, 8'h00, 1'b1, 1'b1);
        send_item(OP_DATA, 8'h81, 1'b1, 1'b0);
        flush_pins();
    endtask

    task automatic test_directed_loads();
        write_length(25'd2);
        send_item(OP_START, 8'h00, 1'b0, 1'b0);
        send_item(OP_DATA, 8'h00, 1'b1, 1'b0);
        send_item(OP_FINISH, 8'h00, 1'b1, 1'b1);
        send_item(OP_DATA, 8'hFF, 1'b1, 1'b1);
        send_item(OP_DATA, 8'h55, 1'b1, 1'b1);
        send_item(OP_FINISH, 8'hFF, 1'b0, 1'b1);
        send_item(OP_DATA, 8'h12, 1'b1, 1'b1);
        send_item(OP_FINISH, 8'h00, 1'b1, 1'b1);
        send_item(OP_START, 8'h00, 1'b0, 1'b1);
        send_item(OP_DATA, 8'hA5, 1'b0, 1'b1);
        send_item(OP_DATA, 8'h01, 1'b1, 1'b1);
        send_item(OP_START, 8'h00, 1'b0, 1'b1);
        send_item(OP_DATA, 8'h5A, 1'b1, 1'b0);
        send_item(OP_DATA, 8'h80, 1'b1, 1'b1);
        send_item(OP_FINISH, 8'h00, 1'b1, 1'b0);
        flush_pins();
    endtask

    task automatic test_zero_length();
        write_length('0);
        send_item(OP_START, 8'h00, 1'b0, 1'b0);
        send_item(OP_FINISH, 8'h00, 1'b1, 1'b1);
        flush_pins();
    endtask

    task automatic test_length_lowered();
        write_length(25'd16777216);
        send_item(OP_START, 8'h00, 1'b0, 1'b0);
        send_item(OP_DATA, 8'hC3, 1'b1, 1'b0);
        send_item(OP_DATA, 8'h7E, 1'b1, 1'b0);
        flush_pins();
        write_length(25'd1);
        send_item(OP_FINISH, 8'h00, 1'b1, 1'b1);
        flush_pins();
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        write_length(25'd64);
        send_item(OP_START, 8'h00, 1'b0, 1'b0);
        hold_len = 400;
        hold_seq++;
        repeat (20)
            send_item(OP_DATA, 8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)));
        flush_pins();
    endtask

    task automatic test_random_loads();
        int goal;
        int done_before;
        int nb;
        goal = items_sent + RANDOM_ITEMS;
        done_before = items_sent;
        write_length(25'($urandom_range(8)));
        while (items_sent < goal) begin
            // A stretch in the middle runs with no idling on either side.
            gaps_on = !(items_sent - done_before >= 150 && items_sent - done_before < 240);
            if ($urandom_range(3) == 0) begin
                flush_pins();
                write_length(25'($urandom_range(8)));
            end
            send_item(OP_START, 8'($urandom_range(255)), $urandom_range(9) == 0,
                      1'($urandom_range(1)));
            nb = int'(stream_len);
            if ($urandom_range(9) == 0)
                nb = $urandom_range(nb + 1);
            for (int i = 0; i < nb; i++) begin
                if ($urandom_range(19) == 0)
                    send_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
                send_item(OP_DATA, 8'($urandom_range(255)), $urandom_range(24) != 0,
                          1'($urandom_range(1)));
            end
            send_item(OP_FINISH, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      $urandom_range(7) != 0);
        end
        flush_pins();
    endtask

    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else begin
                out_stall <= gaps_on && ($urandom_range(99) < 37);
            end
        end
    end

    always @(posedge clk) begin
        pin_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pins_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pin result: ncfg %0d dclk %0d data %0d status %0d last %0d",
                             nconfig_level, dclk_level, data_level, status, last);
            end
            else begin
                want = pins_due.pop_front();
                if (want.ncfg !== nconfig_level || want.dclk !== dclk_level ||
                    want.dat !== data_level || want.st !== status || want.lst !== last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pin mismatch: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                                 want.ncfg, want.dclk, want.dat, want.st, want.lst,
                                 nconfig_level, dclk_level, data_level, status, last);
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb failed");
        $finish;
    end

    initial begin
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        in_valid        = 1'b0;
        opcode          = OP_START;
        data_byte       = '0;
        nstatus_level   = 1'b0;
        conf_done_level = 1'b0;
        load_phase      = PH_IDLE;
        shifted_bytes   = '0;
        stream_len      = LEN_RESET;
        data_pin        = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        gaps_on = 1'b1;
        test_out_of_sequence();
        test_directed_loads();
        test_zero_length();
        test_length_lowered();
        test_backpressure();
        test_random_loads();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
